>>> rtl/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared codes, channel state type and the PWM compare table of the servo
// recipe sequencer.
// ----------------------------------------------------------------------------
package rsq_pkg;

	localparam int RECIPE_DEPTH_DEF = 32;
	localparam int CHANNELS_DEF     = 2;
	localparam int WORD_W           = 8;

	// Item modes.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_CMD  = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	// User commands.
	localparam logic [2:0] CMD_PAUSE    = 3'd0;
	localparam logic [2:0] CMD_CONTINUE = 3'd1;
	localparam logic [2:0] CMD_RIGHT    = 3'd2;
	localparam logic [2:0] CMD_LEFT     = 3'd3;
	localparam logic [2:0] CMD_NOOP     = 3'd4;
	localparam logic [2:0] CMD_BEGIN    = 3'd5;

	// Events that command decode hands to the run-state machine.
	localparam logic [2:0] EV_PAUSE = 3'd0;
	localparam logic [2:0] EV_CONT  = 3'd1;
	localparam logic [2:0] EV_RIGHT = 3'd2;
	localparam logic [2:0] EV_LEFT  = 3'd3;
	localparam logic [2:0] EV_NOOP  = 3'd4;
	localparam logic [2:0] EV_START = 3'd5;
	localparam logic [2:0] EV_ENDED = 3'd6;

	// Recipe opcodes (top three bits of a recipe word).
	localparam logic [2:0] OP_END      = 3'd0;
	localparam logic [2:0] OP_MOVE     = 3'd1;
	localparam logic [2:0] OP_WAIT     = 3'd2;
	localparam logic [2:0] OP_LOOP     = 3'd4;
	localparam logic [2:0] OP_LOOP_END = 3'd5;

	// Run states.
	localparam logic [1:0] ST_AT_POS  = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_MOVING  = 2'd2;
	localparam logic [1:0] ST_ENDED   = 2'd3;

	// Run status.
	localparam logic [1:0] SS_RUN      = 2'd0;
	localparam logic [1:0] SS_PAUSED   = 2'd1;
	localparam logic [1:0] SS_CMD_ERR  = 2'd2;
	localparam logic [1:0] SS_NEST_ERR = 2'd3;

	localparam logic [2:0] POS_MAX       = 3'd5;
	localparam logic [5:0] COMPARE_RESET = 6'd50;

	// Per-channel state that does not depend on the recipe depth.
	typedef struct packed {
		logic [4:0] wait_left;
		logic [4:0] loop_left;
		logic       in_loop;
		logic [2:0] pos;
		logic [1:0] run_state;
		logic [1:0] run_status;
		logic [5:0] compare;
	} chan_t;

	localparam chan_t CHAN_RESET = '{
		wait_left:  5'd0,
		loop_left:  5'd0,
		in_loop:    1'b0,
		pos:        3'd0,
		run_state:  ST_UNKNOWN,
		run_status: SS_RUN,
		compare:    COMPARE_RESET
	};

	// Control fields of one item as seen by the execution logic.
	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] command;
	} item_ctl_t;

	function automatic logic [5:0] pwm_compare(input logic [2:0] pos);
		logic [5:0] v;
		case (pos)
			3'd0:    v = 6'd20;
			3'd1:    v = 6'd17;
			3'd2:    v = 6'd14;
			3'd3:    v = 6'd11;
			3'd4:    v = 6'd8;
			3'd5:    v = 6'd4;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/rsq_store.sv
// ----------------------------------------------------------------------------
// rsq_store
// Recipe register file: one write port, one combinational read port, cleared
// to recipe end at reset.
// ----------------------------------------------------------------------------
module rsq_store #(
	parameter int DEPTH = rsq_pkg::RECIPE_DEPTH_DEF,
	parameter int AW    = $clog2(rsq_pkg::RECIPE_DEPTH_DEF)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [rsq_pkg::WORD_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [rsq_pkg::WORD_W-1:0] rd_data
);
	import rsq_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_addr];

endmodule

>>> rtl/rsq_exec.sv
// ----------------------------------------------------------------------------
// rsq_exec
// Next-state logic of one channel for one item: tick execution of a recipe
// word or user command decode and run-state update.
// ----------------------------------------------------------------------------
module rsq_exec #(
	parameter int DEPTH = rsq_pkg::RECIPE_DEPTH_DEF,
	parameter int AW    = $clog2(rsq_pkg::RECIPE_DEPTH_DEF)
) (
	input  rsq_pkg::item_ctl_t         ctl,
	input  logic [rsq_pkg::WORD_W-1:0] word,
	input  rsq_pkg::chan_t             cur,
	input  logic [AW-1:0]              cur_pc,
	input  logic [AW-1:0]              cur_origin,
	output rsq_pkg::chan_t             nxt,
	output logic [AW-1:0]              nxt_pc,
	output logic [AW-1:0]              nxt_origin
);
	import rsq_pkg::*;

	logic [2:0]    op;
	logic [4:0]    arg;
	logic          ended;
	logic          err;
	logic          paused;
	logic [2:0]    pos_right;
	logic [2:0]    pos_left;
	logic [2:0]    ev;
	logic          cmd_ok;
	logic [AW-1:0] jump_pc;

	assign op        = word[7:5];
	assign arg       = word[4:0];
	assign ended     = (cur.run_state == ST_ENDED);
	assign err       = (cur.run_status == SS_CMD_ERR);
	assign paused    = (cur.run_status == SS_PAUSED);
	assign pos_right = cur.pos - 3'd1;
	assign pos_left  = cur.pos + 3'd1;

	always_comb begin
		nxt        = cur;
		nxt_pc     = cur_pc;
		nxt_origin = cur_origin;
		jump_pc    = cur_pc;
		ev         = EV_NOOP;
		cmd_ok     = 1'b0;
		unique case (ctl.mode)
			MODE_TICK: begin
				if (cur.wait_left != 5'd0) begin
					nxt.wait_left = cur.wait_left - 5'd1;
				end else if (!ended && !paused) begin
					unique case (op)
						OP_MOVE: begin
							if (arg > 5'(POS_MAX)) begin
								nxt.run_status = SS_CMD_ERR;
							end else begin
								nxt.compare    = pwm_compare(arg[2:0]);
								nxt.pos        = arg[2:0];
								nxt.run_status = SS_RUN;
							end
						end
						OP_WAIT: begin
							nxt.wait_left  = arg;
							nxt.run_status = SS_RUN;
						end
						OP_LOOP: begin
							if (cur.in_loop) begin
								nxt.run_status = SS_NEST_ERR;
							end else begin
								nxt.run_status = SS_RUN;
								nxt.loop_left  = arg;
								nxt.in_loop    = 1'b1;
								nxt_origin     = cur_pc;
							end
						end
						OP_LOOP_END: begin
							nxt.run_status = SS_RUN;
							if (cur.loop_left != 5'd0) begin
								nxt.loop_left = cur.loop_left - 5'd1;
								jump_pc       = cur_origin;
							end else begin
								nxt.in_loop = 1'b0;
								nxt_origin  = '0;
							end
						end
						OP_END: begin
							nxt.run_status = SS_RUN;
							nxt.run_state  = ST_ENDED;
						end
						default: begin
							nxt.run_status = SS_CMD_ERR;
						end
					endcase
					nxt_pc = (jump_pc == AW'(DEPTH - 1)) ? '0 : jump_pc + AW'(1);
				end
			end
			MODE_CMD: begin
				cmd_ok = 1'b1;
				unique case (ctl.command)
					CMD_PAUSE: begin
						if (ended) begin
							ev             = EV_ENDED;
							nxt.run_status = SS_PAUSED;
						end else if (err) begin
							ev = EV_NOOP;
						end else begin
							ev             = EV_PAUSE;
							nxt.run_status = SS_PAUSED;
						end
					end
					CMD_CONTINUE: ev = ended ? EV_ENDED : (err ? EV_NOOP : EV_CONT);
					CMD_RIGHT:    ev = (paused && cur.pos > 3'd0) ? EV_RIGHT : EV_NOOP;
					CMD_LEFT:     ev = (paused && cur.pos < POS_MAX) ? EV_LEFT : EV_NOOP;
					CMD_NOOP:     ev = EV_NOOP;
					CMD_BEGIN:    ev = EV_START;
					default:      cmd_ok = 1'b0;
				endcase
				if (cmd_ok) begin
					unique case (cur.run_state) inside
						ST_AT_POS, ST_MOVING: begin
							case (ev)
								EV_PAUSE: begin
									nxt.run_state  = ST_AT_POS;
									nxt.run_status = SS_PAUSED;
								end
								EV_RIGHT: begin
									nxt.pos        = pos_right;
									nxt.compare    = pwm_compare(pos_right);
									nxt.run_state  = ST_MOVING;
									nxt.run_status = SS_RUN;
								end
								EV_LEFT: begin
									nxt.pos        = pos_left;
									nxt.compare    = pwm_compare(pos_left);
									nxt.run_state  = ST_MOVING;
									nxt.run_status = SS_RUN;
								end
								EV_NOOP: begin
									if (cur.run_state == ST_AT_POS) begin
										nxt.run_status = SS_PAUSED;
									end else begin
										nxt.run_status = SS_RUN;
									end
								end
								EV_ENDED: begin
									nxt.run_state  = ST_ENDED;
									nxt.run_status = SS_PAUSED;
								end
								default: begin
									nxt.run_state  = ST_MOVING;
									nxt.run_status = SS_RUN;
								end
							endcase
						end
						ST_ENDED: begin
							if (ev == EV_START) begin
								nxt.run_state  = ST_MOVING;
								nxt.run_status = SS_RUN;
							end else begin
								nxt.run_status = SS_PAUSED;
							end
						end
						default: begin
							// Unknown state ignores events; only the pause decode acts.
						end
					endcase
				end
			end
			default: begin
				// Loads and the unused mode leave the channel alone.
			end
		endcase
	end

endmodule

>>> rtl/servo_recipe_sequencer.sv
// ----------------------------------------------------------------------------
// servo_recipe_sequencer
// Recipe interpreter for several servo channels sharing one recipe store.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                  Payload
// item      item_valid / item_stall    mode, channel, command, load_address,
//                                      load_data
// result    result_valid / result_stall out_channel, compare_value, servo_pos,
//                                      run_state, run_status
//
// One item is accepted every cycle while the result side keeps up. An item
// is held in the input register, where the store read, opcode decode and
// channel state update are done, and its result moves on into the result
// register when that register is free.
// Reset clears the recipe store, every channel and the valid flags of both
// pipeline registers at once; the block accepts items as soon as reset ends.
// A stall on the result side holds the result register; the input register
// then holds its item and item_stall rises, so nothing is lost or repeated.
//
module servo_recipe_sequencer #(
	parameter int RECIPE_DEPTH = rsq_pkg::RECIPE_DEPTH_DEF,
	parameter int CHANNELS     = rsq_pkg::CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] mode,
	input  logic       channel,
	input  logic [2:0] command,
	input  logic [4:0] load_address,
	input  logic [7:0] load_data,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       out_channel,
	output logic [5:0] compare_value,
	output logic [2:0] servo_pos,
	output logic [1:0] run_state,
	output logic [1:0] run_status
);
	import rsq_pkg::*;

	localparam int AW = $clog2(RECIPE_DEPTH);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Load addresses wrap around the store depth. The address is five bits
	// wide, so the compare and subtract loop covers any depth of four or more.
	function automatic logic [AW-1:0] wrap_addr(input logic [4:0] a);
		logic [8:0] v;
		v = 9'(a);
		for (int i = 0; i < 8; i++) begin
			if (v >= 9'(RECIPE_DEPTH)) begin
				v = v - 9'(RECIPE_DEPTH);
			end
		end
		return AW'(v);
	endfunction

	// Input register.
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [CW-1:0]     channel_s1;
	logic [2:0]        command_s1;
	logic [AW-1:0]     load_address_s1;
	logic [WORD_W-1:0] load_data_s1;

	// Result register.
	logic       result_valid_q;
	logic       out_channel_q;
	logic [5:0] compare_value_q;
	logic [2:0] servo_pos_q;
	logic [1:0] run_state_q;
	logic [1:0] run_status_q;

	// Channel state.
	chan_t         chan_q   [CHANNELS];
	logic [AW-1:0] pc_q     [CHANNELS];
	logic [AW-1:0] origin_q [CHANNELS];

	logic              out_free;
	logic              fire_s1;
	logic [CW-1:0]     channel_in;
	logic [WORD_W-1:0] word;
	item_ctl_t         ctl;
	chan_t             nxt;
	logic [AW-1:0]     nxt_pc;
	logic [AW-1:0]     nxt_origin;

	// The result register can take a new result when it is empty or its
	// current result leaves this cycle. The input register moves on then.
	assign out_free   = !result_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// The channel field wraps modulo the channel count.
	assign channel_in = (CHANNELS > 1) ? CW'(channel) : CW'(0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1         <= mode;
			channel_s1      <= channel_in;
			command_s1      <= command;
			load_address_s1 <= wrap_addr(load_address);
			load_data_s1    <= load_data;
		end
	end

	// The store is written by load items and read at the program counter of
	// the channel that the item in the input register targets.
	rsq_store #(
		.DEPTH(RECIPE_DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fire_s1 && (mode_s1 == MODE_LOAD)),
		.wr_addr(load_address_s1),
		.wr_data(load_data_s1),
		.rd_addr(pc_q[channel_s1]),
		.rd_data(word)
	);

	assign ctl.mode    = mode_s1;
	assign ctl.command = command_s1;

	rsq_exec #(
		.DEPTH(RECIPE_DEPTH),
		.AW   (AW)
	) u_exec (
		.ctl       (ctl),
		.word      (word),
		.cur       (chan_q[channel_s1]),
		.cur_pc    (pc_q[channel_s1]),
		.cur_origin(origin_q[channel_s1]),
		.nxt       (nxt),
		.nxt_pc    (nxt_pc),
		.nxt_origin(nxt_origin)
	);

	// Only the targeted channel is written. Loads and ignored items give back
	// the current state, so the write is harmless for them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i]   <= CHAN_RESET;
				pc_q[i]     <= '0;
				origin_q[i] <= '0;
			end
		end else if (fire_s1) begin
			chan_q[channel_s1]   <= nxt;
			pc_q[channel_s1]     <= nxt_pc;
			origin_q[channel_s1] <= nxt_origin;
		end
	end

	// The result reports the channel as it stands after the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_channel_q   <= channel_s1[0];
			compare_value_q <= nxt.compare;
			servo_pos_q     <= nxt.pos;
			run_state_q     <= nxt.run_state;
			run_status_q    <= nxt.run_status;
		end
	end

	assign result_valid  = result_valid_q;
	assign out_channel   = out_channel_q;
	assign compare_value = compare_value_q;
	assign servo_pos     = servo_pos_q;
	assign run_state     = run_state_q;
	assign run_status    = run_status_q;

`ifndef SYNTHESIS
	// An item that leaves the input register always lands in the result register.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> result_valid)
		else $error("item left the input register without a result");

	// The compare value follows the reported position, apart from the reset value.
	a_compare_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (compare_value == pwm_compare(servo_pos)) ||
			(compare_value == COMPARE_RESET && servo_pos == 3'd0))
		else $error("compare value does not match servo position");

	// An ended recipe reports only running or paused.
	a_ended_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && run_state == ST_ENDED) |->
			(run_status == SS_RUN || run_status == SS_PAUSED))
		else $error("ended channel reports an error status");
`endif

endmodule
